>>> rtl/epjm_pkg.sv
// ----------------------------------------------------------------------------
// epjm_pkg
// Shared constants for the event period and jitter monitor.
// ----------------------------------------------------------------------------
package epjm_pkg;

    // Default sizes of the timestamp, gap and window sample counter.
    localparam int TIME_BITS_DEF  = 48;
    localparam int GAP_BITS_DEF   = 24;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int PERIOD_BITS    = 24;
    localparam int RATIO_BITS     = 16;
    localparam int COUNTER_BITS   = 32;
    localparam int RATE_BITS      = 32;

    // Function codes carried by an input transaction.
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;
    localparam logic [1:0] FUNC_STOP  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECK_ENABLE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_RATIO = 2'd2;

    // Configuration reset values.
    localparam logic [PERIOD_BITS-1:0] EXPECTED_PERIOD_RESET = 24'd100000;
    localparam logic [RATIO_BITS-1:0]  THRESHOLD_RATIO_RESET = 16'd6554;

    // Period check arithmetic: ratios are in units of 1/65536.
    localparam int              RATIO_ONE_BITS = RATIO_BITS + 1;
    localparam logic [RATIO_ONE_BITS-1:0] RATIO_ONE = 17'h10000;
    localparam int              BOUND_BITS     = PERIOD_BITS + RATIO_ONE_BITS;
    localparam int              CLAMP_SHIFT    = 26;
    localparam int              SCALED_BITS    = CLAMP_SHIFT + 1 + RATIO_BITS;

    // Samples per second times 256, with time in microseconds.
    localparam int                         RATE_SCALE_BITS = 28;
    localparam logic [RATE_SCALE_BITS-1:0] RATE_SCALE      = 28'd256000000;

    // Report queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

endpackage

>>> rtl/epjm_front.sv
// ----------------------------------------------------------------------------
// epjm_front
// Accepts transactions, keeps the window statistics and cumulative counters,
// and queues a snapshot of the window for every report.
// ----------------------------------------------------------------------------
module epjm_front #(
    parameter int TIME_BITS  = epjm_pkg::TIME_BITS_DEF,
    parameter int GAP_BITS   = epjm_pkg::GAP_BITS_DEF,
    parameter int COUNT_BITS = epjm_pkg::COUNT_BITS_DEF,
    parameter int SNAP_W     = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [epjm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [epjm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          func,
    input  logic [TIME_BITS-1:0]                time_us,
    output logic                                q_push,
    output logic [SNAP_W-1:0]                   q_data,
    input  logic                                q_full
);

    localparam int SUM_W = GAP_BITS + COUNT_BITS;
    localparam int SQ_W  = 2 * GAP_BITS + COUNT_BITS;
    localparam int CS    = epjm_pkg::CLAMP_SHIFT;
    localparam logic [TIME_BITS-1:0] CLAMP_LIMIT = TIME_BITS'(1) << CS;

    typedef enum logic [4:0] {
        F_IDLE   = 5'b00001,
        F_EXEC   = 5'b00010,
        F_GAP    = 5'b00100,
        F_SQUARE = 5'b01000,
        F_ACCUM  = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic                                   check_enable_reg;
    logic [epjm_pkg::PERIOD_BITS-1:0]       period_reg;
    logic [epjm_pkg::RATIO_BITS-1:0]        ratio_reg;
    logic [epjm_pkg::BOUND_BITS-1:0]        upper_reg, lower_reg;

    logic [1:0]                 func_reg;
    logic [TIME_BITS-1:0]       time_reg;
    logic                       running_reg, have_prev_reg;
    logic [TIME_BITS-1:0]       prev_stamp_reg, read_stamp_reg;
    logic [COUNT_BITS-1:0]      samples_reg;
    logic [GAP_BITS-1:0]        gap_min_reg, gap_max_reg;
    logic [SUM_W-1:0]           gap_sum_reg;
    logic [SQ_W-1:0]            gap_sq_sum_reg;
    logic [epjm_pkg::COUNTER_BITS-1:0] checks_reg, violations_reg;
    logic [TIME_BITS-1:0]       gap_reg;
    logic [GAP_BITS-1:0]        g_reg;
    logic [2*GAP_BITS-1:0]      square_reg;

    logic                                accept;
    logic [GAP_BITS-1:0]                 g_sat;
    logic [CS:0]                         clamped;
    logic [epjm_pkg::SCALED_BITS-1:0]    scaled;
    logic                                violation;
    logic [TIME_BITS-1:0]                duration;

    always_comb
    begin
        full     = (state_reg != F_IDLE) || q_full;
        accept   = push && !full;
        g_sat    = (|gap_reg[TIME_BITS-1:GAP_BITS]) ? '1 : gap_reg[GAP_BITS-1:0];
        clamped  = (gap_reg > CLAMP_LIMIT) ? CLAMP_LIMIT[CS:0] : gap_reg[CS:0];
        scaled   = {clamped, {epjm_pkg::RATIO_BITS{1'b0}}};
        violation = (scaled > epjm_pkg::SCALED_BITS'(upper_reg))
                 || (scaled < epjm_pkg::SCALED_BITS'(lower_reg));
        duration = time_reg - read_stamp_reg;
        q_push   = (state_reg == F_EXEC) && (func_reg == epjm_pkg::FUNC_READ)
                && running_reg;
        q_data   = {samples_reg, duration, gap_max_reg, gap_min_reg,
                    gap_sum_reg, gap_sq_sum_reg, violations_reg, checks_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:   if (accept) state_next = F_EXEC;
            F_EXEC:   state_next = ((func_reg == epjm_pkg::FUNC_PUSH) && have_prev_reg)
                                 ? F_GAP : F_IDLE;
            F_GAP:    state_next = F_SQUARE;
            F_SQUARE: state_next = F_ACCUM;
            F_ACCUM:  state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    // Bounds follow the configuration in the next cycle.
    always_ff @(posedge clk)
    begin
        upper_reg  <= epjm_pkg::BOUND_BITS'(period_reg)
                    * epjm_pkg::BOUND_BITS'(epjm_pkg::RATIO_ONE
                    + epjm_pkg::RATIO_ONE_BITS'(ratio_reg));
        lower_reg  <= epjm_pkg::BOUND_BITS'(period_reg)
                    * epjm_pkg::BOUND_BITS'(epjm_pkg::RATIO_ONE
                    - epjm_pkg::RATIO_ONE_BITS'(ratio_reg));
        square_reg <= (2*GAP_BITS)'(g_reg) * (2*GAP_BITS)'(g_reg);
        if (accept)
        begin
            func_reg <= func;
            time_reg <= time_us;
        end
        if (state_reg == F_EXEC)
            gap_reg <= time_reg - prev_stamp_reg;
        if (state_reg == F_GAP)
            g_reg <= g_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= F_IDLE;
            check_enable_reg <= 1'b0;
            period_reg       <= epjm_pkg::EXPECTED_PERIOD_RESET;
            ratio_reg        <= epjm_pkg::THRESHOLD_RATIO_RESET;
            running_reg      <= 1'b0;
            have_prev_reg    <= 1'b0;
            prev_stamp_reg   <= '0;
            read_stamp_reg   <= '0;
            samples_reg      <= '0;
            gap_min_reg      <= '1;
            gap_max_reg      <= '0;
            gap_sum_reg      <= '0;
            gap_sq_sum_reg   <= '0;
            checks_reg       <= '0;
            violations_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    epjm_pkg::CFG_CHECK_ENABLE:    check_enable_reg <= cfg_data[0];
                    epjm_pkg::CFG_EXPECTED_PERIOD:
                        period_reg <= cfg_data[epjm_pkg::PERIOD_BITS-1:0];
                    epjm_pkg::CFG_THRESHOLD_RATIO:
                        ratio_reg <= cfg_data[epjm_pkg::RATIO_BITS-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                F_EXEC:
                begin
                    case (func_reg)
                        epjm_pkg::FUNC_PUSH:
                        begin
                            prev_stamp_reg <= time_reg;
                            have_prev_reg  <= 1'b1;
                            if (!have_prev_reg && (samples_reg != '1))
                                samples_reg <= samples_reg + 1'b1;
                        end
                        epjm_pkg::FUNC_READ, epjm_pkg::FUNC_START:
                        begin
                            if (running_reg || (func_reg == epjm_pkg::FUNC_START))
                            begin
                                read_stamp_reg <= time_reg;
                                samples_reg    <= '0;
                                have_prev_reg  <= 1'b0;
                                gap_min_reg    <= '1;
                                gap_max_reg    <= '0;
                                gap_sum_reg    <= '0;
                                gap_sq_sum_reg <= '0;
                            end
                            if (func_reg == epjm_pkg::FUNC_START)
                                running_reg <= 1'b1;
                        end
                        epjm_pkg::FUNC_STOP: running_reg <= 1'b0;
                        default: ;
                    endcase
                end
                F_GAP:
                begin
                    if (check_enable_reg)
                    begin
                        checks_reg <= checks_reg + 1'b1;
                        if (violation)
                            violations_reg <= violations_reg + 1'b1;
                    end
                end
                F_ACCUM:
                begin
                    // A full window keeps its statistics frozen.
                    if (samples_reg != '1)
                    begin
                        if (g_reg < gap_min_reg) gap_min_reg <= g_reg;
                        if (g_reg > gap_max_reg) gap_max_reg <= g_reg;
                        gap_sum_reg    <= gap_sum_reg + SUM_W'(g_reg);
                        gap_sq_sum_reg <= gap_sq_sum_reg + SQ_W'(square_reg);
                        samples_reg    <= samples_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/epjm_queue.sv
// ----------------------------------------------------------------------------
// epjm_queue
// Short report queue with a registered read port.
// ----------------------------------------------------------------------------
module epjm_queue #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int DEPTH = epjm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/epjm_back.sv
// ----------------------------------------------------------------------------
// epjm_back
// Turns a window snapshot into a report: rate by long division, standard
// deviation by shift-add products, a digit-by-digit square root and a
// second pass through the divider.
// ----------------------------------------------------------------------------
module epjm_back #(
    parameter int TIME_BITS  = epjm_pkg::TIME_BITS_DEF,
    parameter int GAP_BITS   = epjm_pkg::GAP_BITS_DEF,
    parameter int COUNT_BITS = epjm_pkg::COUNT_BITS_DEF,
    parameter int SNAP_W     = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    output logic                              q_pop,
    input  logic [SNAP_W-1:0]                 q_data,
    input  logic                              q_empty,
    output logic                              empty,
    input  logic                              pop,
    output logic [COUNT_BITS-1:0]             sample_total,
    output logic [TIME_BITS-1:0]              window_span_us,
    output logic [epjm_pkg::RATE_BITS-1:0]    rate_q8,
    output logic [GAP_BITS-1:0]               max_gap_us,
    output logic [GAP_BITS-1:0]               min_gap_us,
    output logic [GAP_BITS-1:0]               gap_std_dev_us,
    output logic [epjm_pkg::COUNTER_BITS-1:0] violation_count,
    output logic [epjm_pkg::COUNTER_BITS-1:0] check_count
);

    localparam int CB     = epjm_pkg::COUNTER_BITS;
    localparam int SUM_W  = GAP_BITS + COUNT_BITS;
    localparam int SQ_W   = 2 * GAP_BITS + COUNT_BITS;
    localparam int PROD_W = 2 * SUM_W;
    localparam int ROOT_W = SUM_W;
    localparam int NUM_W  = COUNT_BITS + epjm_pkg::RATE_SCALE_BITS;
    localparam int DIVD_W = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;
    localparam int CNT_W  = $clog2(DIVD_W);
    localparam int O_VIOL = CB;
    localparam int O_SQ   = 2 * CB;
    localparam int O_SUM  = O_SQ + SQ_W;
    localparam int O_MIN  = O_SUM + SUM_W;
    localparam int O_MAX  = O_MIN + GAP_BITS;
    localparam int O_DUR  = O_MAX + GAP_BITS;
    localparam int O_SAMP = O_DUR + TIME_BITS;

    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001,
        B_LOAD = 8'b00000010,
        B_RDIV = 8'b00000100,
        B_MUL  = 8'b00001000,
        B_SUB  = 8'b00010000,
        B_SQRT = 8'b00100000,
        B_SDIV = 8'b01000000,
        B_DONE = 8'b10000000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;

    logic [COUNT_BITS-1:0] samples_reg, n_reg;
    logic [TIME_BITS-1:0]  dur_reg;
    logic [GAP_BITS-1:0]   gmax_reg, gmin_reg, std_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [CB-1:0]         viol_reg, chk_reg;
    logic [epjm_pkg::RATE_BITS-1:0] rate_reg;

    logic [PROD_W-1:0]   a_reg, b_reg, x_reg;
    logic [SUM_W-1:0]    nsh_reg, ssh_reg;
    logic [ROOT_W+1:0]   srem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [DIVD_W-1:0]   dvd_reg, quo_reg;
    logic [TIME_BITS-1:0] dvs_reg;
    logic [TIME_BITS:0]  drem_reg;

    logic [PROD_W-1:0]   a_next, b_next;
    logic [ROOT_W+1:0]   s_shift, s_trial, srem_next;
    logic                s_ge;
    logic [ROOT_W-1:0]   root_next;
    logic [TIME_BITS:0]  d_shift, drem_next;
    logic                d_ge;
    logic [DIVD_W-1:0]   quo_next;
    logic                done_cnt, out_load, rate_sat;

    always_comb
    begin
        a_next    = (a_reg << 1) + (nsh_reg[SUM_W-1] ? PROD_W'(sq_reg) : '0);
        b_next    = (b_reg << 1) + (ssh_reg[SUM_W-1] ? PROD_W'(sum_reg) : '0);
        s_shift   = {srem_reg[ROOT_W-1:0], x_reg[PROD_W-1:PROD_W-2]};
        s_trial   = {root_reg, 2'b01};
        s_ge      = (s_shift >= s_trial);
        srem_next = s_ge ? s_shift - s_trial : s_shift;
        root_next = {root_reg[ROOT_W-2:0], s_ge};
        d_shift   = {drem_reg[TIME_BITS-1:0], dvd_reg[DIVD_W-1]};
        d_ge      = (d_shift >= {1'b0, dvs_reg});
        drem_next = d_ge ? d_shift - {1'b0, dvs_reg} : d_shift;
        quo_next  = {quo_reg[DIVD_W-2:0], d_ge};
        rate_sat  = (dur_reg == '0) || (|quo_next[DIVD_W-1:epjm_pkg::RATE_BITS]);
        done_cnt  = (cnt_reg == '0);
        out_load  = (state_reg == B_DONE) && (!out_valid_reg || pop);
        q_pop     = (state_reg == B_IDLE) && !q_empty;
        empty     = !out_valid_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (!q_empty) state_next = B_LOAD;
            B_LOAD: state_next = B_RDIV;
            B_RDIV: if (done_cnt) state_next = B_MUL;
            B_MUL:  if (done_cnt) state_next = B_SUB;
            B_SUB:  state_next = B_SQRT;
            B_SQRT: if (done_cnt) state_next = B_SDIV;
            B_SDIV: if (done_cnt) state_next = B_DONE;
            B_DONE: if (out_load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_LOAD:
            begin
                samples_reg <= q_data[O_SAMP +: COUNT_BITS];
                n_reg       <= (q_data[O_SAMP +: COUNT_BITS] == '0) ? '0
                             : q_data[O_SAMP +: COUNT_BITS] - 1'b1;
                dur_reg     <= q_data[O_DUR +: TIME_BITS];
                gmax_reg    <= q_data[O_MAX +: GAP_BITS];
                gmin_reg    <= q_data[O_MIN +: GAP_BITS];
                sum_reg     <= q_data[O_SUM +: SUM_W];
                sq_reg      <= q_data[O_SQ +: SQ_W];
                viol_reg    <= q_data[O_VIOL +: CB];
                chk_reg     <= q_data[CB-1:0];
                dvd_reg     <= DIVD_W'(NUM_W'(q_data[O_SAMP +: COUNT_BITS])
                             * NUM_W'(epjm_pkg::RATE_SCALE));
                dvs_reg     <= q_data[O_DUR +: TIME_BITS];
                drem_reg    <= '0;
                cnt_reg     <= CNT_W'(DIVD_W - 1);
            end
            B_RDIV:
            begin
                dvd_reg  <= dvd_reg << 1;
                drem_reg <= drem_next;
                quo_reg  <= quo_next;
                if (done_cnt)
                begin
                    rate_reg <= rate_sat ? '1 : quo_next[epjm_pkg::RATE_BITS-1:0];
                    a_reg    <= '0;
                    b_reg    <= '0;
                    nsh_reg  <= SUM_W'(n_reg);
                    ssh_reg  <= sum_reg;
                    cnt_reg  <= CNT_W'(SUM_W - 1);
                end
                else
                    cnt_reg  <= cnt_reg - 1'b1;
            end
            B_MUL:
            begin
                a_reg   <= a_next;
                b_reg   <= b_next;
                nsh_reg <= nsh_reg << 1;
                ssh_reg <= ssh_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            B_SUB:
            begin
                // n * sum of squares minus the squared sum, never below zero.
                x_reg    <= (a_reg > b_reg) ? a_reg - b_reg : '0;
                srem_reg <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            B_SQRT:
            begin
                x_reg    <= x_reg << 2;
                srem_reg <= srem_next;
                root_reg <= root_next;
                if (done_cnt)
                begin
                    dvd_reg  <= DIVD_W'(root_next);
                    dvs_reg  <= TIME_BITS'(n_reg);
                    drem_reg <= '0;
                    cnt_reg  <= CNT_W'(DIVD_W - 1);
                end
                else
                    cnt_reg  <= cnt_reg - 1'b1;
            end
            B_SDIV:
            begin
                dvd_reg  <= dvd_reg << 1;
                drem_reg <= drem_next;
                quo_reg  <= quo_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (done_cnt)
                    std_reg <= (n_reg == '0) ? '0 : quo_next[GAP_BITS-1:0];
            end
            default: ;
        endcase
        if (out_load)
        begin
            sample_total    <= samples_reg;
            window_span_us  <= dur_reg;
            rate_q8         <= rate_reg;
            max_gap_us      <= (n_reg == '0) ? '0 : gmax_reg;
            min_gap_us      <= (n_reg == '0) ? '0 : gmin_reg;
            gap_std_dev_us  <= std_reg;
            violation_count <= viol_reg;
            check_count     <= chk_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/event_period_jitter_monitor.sv
// ----------------------------------------------------------------------------
// event_period_jitter_monitor
// Period and jitter monitor for a stream of timestamped events.
// ----------------------------------------------------------------------------
// Each input transaction carries a function code (push, read, start, stop) and
// a microsecond timestamp; only a read while running produces a result. A
// push that follows an earlier one in the window passes through the front
// part in steps (accept, gap, period check, square, accumulate); read, start,
// stop and a first push only take the accept and execute steps. Reads place
// a snapshot of the window into a two-entry queue, and the back part turns
// each snapshot into a report, one bit per cycle through a shared restoring
// divider (rate, then standard deviation over n), a shift-add multiplier pair
// and a digit-by-digit square root. The input side reports full while the
// front part works or the queue is full; a finished report sits in an output
// register until popped, while the back part already works on the next one.
// Configuration is written through cfg_write, cfg_index and cfg_data and must
// only change while the block is idle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module event_period_jitter_monitor #(
    parameter int TIME_BITS  = epjm_pkg::TIME_BITS_DEF,
    parameter int GAP_BITS   = epjm_pkg::GAP_BITS_DEF,
    parameter int COUNT_BITS = epjm_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [epjm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [epjm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          func,
    input  logic [TIME_BITS-1:0]                time_us,
    output logic                                empty,
    input  logic                                pop,
    output logic [COUNT_BITS-1:0]               sample_total,
    output logic [TIME_BITS-1:0]                window_span_us,
    output logic [epjm_pkg::RATE_BITS-1:0]      rate_q8,
    output logic [GAP_BITS-1:0]                 max_gap_us,
    output logic [GAP_BITS-1:0]                 min_gap_us,
    output logic [GAP_BITS-1:0]                 gap_std_dev_us,
    output logic [epjm_pkg::COUNTER_BITS-1:0]   violation_count,
    output logic [epjm_pkg::COUNTER_BITS-1:0]   check_count
);

    // Snapshot layout: sample count, duration, max, min, sum, sum of squares
    // and the two cumulative counters.
    localparam int SNAP_W = COUNT_BITS + 2 * TIME_BITS - TIME_BITS + 2 * GAP_BITS
                          + (GAP_BITS + COUNT_BITS) + (2 * GAP_BITS + COUNT_BITS)
                          + 2 * epjm_pkg::COUNTER_BITS;

    logic              q_push, q_full, q_pop, q_empty;
    logic [SNAP_W-1:0] q_wr_data, q_rd_data;

    // The front part updates window state in arrival order and does not wait on
    // report arithmetic directly; it stalls while busy or when the queue is full.
    epjm_front #(
        .TIME_BITS  (TIME_BITS),
        .GAP_BITS   (GAP_BITS),
        .COUNT_BITS (COUNT_BITS),
        .SNAP_W     (SNAP_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .func      (func),
        .time_us   (time_us),
        .q_push    (q_push),
        .q_data    (q_wr_data),
        .q_full    (q_full)
    );

    epjm_queue #(
        .WIDTH (SNAP_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // The back part takes one snapshot at a time and holds the finished
    // report on the result ports until it is popped.
    epjm_back #(
        .TIME_BITS  (TIME_BITS),
        .GAP_BITS   (GAP_BITS),
        .COUNT_BITS (COUNT_BITS),
        .SNAP_W     (SNAP_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_pop           (q_pop),
        .q_data          (q_rd_data),
        .q_empty         (q_empty),
        .empty           (empty),
        .pop             (pop),
        .sample_total    (sample_total),
        .window_span_us  (window_span_us),
        .rate_q8         (rate_q8),
        .max_gap_us      (max_gap_us),
        .min_gap_us      (min_gap_us),
        .gap_std_dev_us  (gap_std_dev_us),
        .violation_count (violation_count),
        .check_count     (check_count)
    );

endmodule

>>> rtl/epjm_checker.sv
// ----------------------------------------------------------------------------
// epjm_checker
// Port-level checks on the reports of the monitor.
// ----------------------------------------------------------------------------
module epjm_checker #(
    parameter int TIME_BITS  = epjm_pkg::TIME_BITS_DEF,
    parameter int GAP_BITS   = epjm_pkg::GAP_BITS_DEF,
    parameter int COUNT_BITS = epjm_pkg::COUNT_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              empty,
    input logic                              pop,
    input logic [COUNT_BITS-1:0]             sample_total,
    input logic [TIME_BITS-1:0]              window_span_us,
    input logic [epjm_pkg::RATE_BITS-1:0]    rate_q8,
    input logic [GAP_BITS-1:0]               max_gap_us,
    input logic [GAP_BITS-1:0]               min_gap_us,
    input logic [GAP_BITS-1:0]               gap_std_dev_us
);

    // A zero-length window saturates the rate.
    a_zero_duration_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (window_span_us == '0)) |-> (rate_q8 == '1))
        else $error("rate not saturated for zero duration");

    // With fewer than two samples there is no gap to report.
    a_no_gap_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (sample_total < COUNT_BITS'(2)))
        |-> ((max_gap_us == '0) && (min_gap_us == '0) && (gap_std_dev_us == '0)))
        else $error("gap statistics reported without gaps");

    // The smallest gap never exceeds the largest one.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (min_gap_us <= max_gap_us))
        else $error("minimum gap above maximum gap");

    // A report that is not taken stays unchanged.
    a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sample_total) && $stable(rate_q8)
                             && $stable(gap_std_dev_us)))
        else $error("waiting report changed");

endmodule

bind event_period_jitter_monitor epjm_checker #(
    .TIME_BITS  (TIME_BITS),
    .GAP_BITS   (GAP_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_epjm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .sample_total   (sample_total),
    .window_span_us (window_span_us),
    .rate_q8        (rate_q8),
    .max_gap_us     (max_gap_us),
    .min_gap_us     (min_gap_us),
    .gap_std_dev_us (gap_std_dev_us)
);
